// ===== rtl/greedy_lpt_work_assigner_assert.svh =====
// Assertion macros used by the work assigner datapath.
`ifndef GREEDY_LPT_WORK_ASSIGNER_ASSERT_SVH
`define GREEDY_LPT_WORK_ASSIGNER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GLWA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GLWA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/glwa_pkg.sv =====
// Shared types and constants of the greedy LPT work assigner.
`default_nettype none

package glwa_pkg;

    localparam int SIZE_W      = 16;
    localparam int JOB_IDX_W   = 6;
    localparam int WORKER_ID_W = 4;
    localparam int CFG_W       = 5;
    localparam int LOAD_W      = 38;

    typedef struct packed {
        logic [SIZE_W-1:0] cols;
        logic [SIZE_W-1:0] rows;
        logic              final_job;
    } in_item_t;

    typedef struct packed {
        logic [JOB_IDX_W-1:0]   job_index;
        logic [WORKER_ID_W-1:0] worker_id;
        logic                   end_of_run;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic store;
        logic run_start;
        logic rank_rd;
        logic rank_init;
        logic rank_scan;
        logic rank_write;
        logic asg_fetch;
        logic asg_init;
        logic asg_scan;
        logic asg_commit;
        logic asg_next;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic final_job;
        logic rank_done;
        logic last_rank;
        logic scan_done;
        logic out_taken;
        logic last_asg;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/glwa_ctrl.sv =====
// Sequencing state machine of the work assigner.
`default_nettype none

module glwa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire glwa_pkg::sts_t  sts,
    output glwa_pkg::cmd_t       cmd
);
    import glwa_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_STORE   = 11'b000_0000_0010,
        ST_RK_RDI  = 11'b000_0000_0100,
        ST_RK_WI   = 11'b000_0000_1000,
        ST_RK_SCAN = 11'b000_0001_0000,
        ST_RK_WR   = 11'b000_0010_0000,
        ST_AS_RDO  = 11'b000_0100_0000,
        ST_AS_RDW  = 11'b000_1000_0000,
        ST_AS_WT   = 11'b001_0000_0000,
        ST_AS_SCAN = 11'b010_0000_0000,
        ST_AS_OUT  = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (sts.final_job)
                begin
                    cmd.run_start = 1'b1;
                    state_next    = ST_RK_RDI;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RK_RDI:
            begin
                cmd.rank_rd = 1'b1;
                state_next  = ST_RK_WI;
            end
            ST_RK_WI:
            begin
                cmd.rank_init = 1'b1;
                state_next    = ST_RK_SCAN;
            end
            ST_RK_SCAN:
            begin
                cmd.rank_scan = 1'b1;
                if (sts.rank_done)
                begin
                    state_next = ST_RK_WR;
                end
            end
            ST_RK_WR:
            begin
                cmd.rank_write = 1'b1;
                state_next     = sts.last_rank ? ST_AS_RDO : ST_RK_RDI;
            end
            ST_AS_RDO:
            begin
                // order memory read of slot k is issued every cycle
                state_next = ST_AS_RDW;
            end
            ST_AS_RDW:
            begin
                cmd.asg_fetch = 1'b1;
                state_next    = ST_AS_WT;
            end
            ST_AS_WT:
            begin
                cmd.asg_init = 1'b1;
                state_next   = ST_AS_SCAN;
            end
            ST_AS_SCAN:
            begin
                if (sts.scan_done)
                begin
                    cmd.asg_commit = 1'b1;
                    state_next     = ST_AS_OUT;
                end
                else
                begin
                    cmd.asg_scan = 1'b1;
                end
            end
            ST_AS_OUT:
            begin
                if (sts.out_taken)
                begin
                    cmd.asg_next = 1'b1;
                    state_next   = sts.last_asg ? ST_IDLE : ST_AS_RDO;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/glwa_datapath.sv =====
// Job store, ranking sort, worker load scan and result register.
`default_nettype none

module glwa_datapath #(
    parameter int MAX_JOBS    = 64,
    parameter int MAX_WORKERS = 16,
    parameter int SIZE_BITS   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire glwa_pkg::in_item_t            in_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [glwa_pkg::CFG_W-1:0]    cfg_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output glwa_pkg::out_item_t                out_data,
    input  wire glwa_pkg::cmd_t                cmd,
    output glwa_pkg::sts_t                     sts
);
    import glwa_pkg::*;

    `include "greedy_lpt_work_assigner_assert.svh"

    localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W  = $clog2(MAX_JOBS + 1);
    localparam int WID_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int WCNT_W = $clog2(MAX_WORKERS + 1);
    localparam int WT_W   = 2 * SIZE_BITS;

    // captured item
    logic [SIZE_BITS-1:0] cols_reg;
    logic [SIZE_BITS-1:0] rows_reg;
    logic                 last_reg;

    logic [CFG_W-1:0]     cfg_reg;
    logic [CNT_W-1:0]     jobs_reg;

    // job weight and sorted order memories
    logic [WT_W-1:0]      wmem [MAX_JOBS];
    logic [WT_W-1:0]      w_rdata_reg;
    logic [IDX_W-1:0]     w_raddr;
    logic [IDX_W-1:0]     smem [MAX_JOBS];
    logic [IDX_W-1:0]     s_rdata_reg;

    // ranking
    logic [CNT_W-1:0]     i_reg;
    logic [CNT_W-1:0]     j_reg;
    logic [CNT_W-1:0]     jd_reg;
    logic [CNT_W-1:0]     rank_reg;
    logic                 pend_reg;
    logic [WT_W-1:0]      wi_reg;

    // assignment
    logic [CNT_W-1:0]     k_reg;
    logic [IDX_W-1:0]     job_reg;
    logic [WT_W-1:0]      wt_reg;
    logic [WCNT_W-1:0]    nw_reg;
    logic [WCNT_W-1:0]    nw_next;
    logic [WCNT_W-1:0]    wk_reg;
    logic [WID_W-1:0]     best_reg;
    logic [LOAD_W-1:0]    best_load_reg;
    logic [LOAD_W-1:0]    loads_reg [MAX_WORKERS];
    logic [LOAD_W-1:0]    scan_load;

    logic                 out_valid_reg;
    out_item_t            out_data_reg;

    logic                 beats_ahead;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign w_raddr = cmd.rank_rd   ? i_reg[IDX_W-1:0] :
                     cmd.rank_scan ? j_reg[IDX_W-1:0] : s_rdata_reg;

    assign scan_load   = loads_reg[wk_reg[WID_W-1:0]];
    assign beats_ahead = (w_rdata_reg > wi_reg) ||
                         ((w_rdata_reg == wi_reg) && (jd_reg < i_reg));

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            nw_next = WCNT_W'(1);
        end
        else if (cfg_reg > CFG_W'(MAX_WORKERS))
        begin
            nw_next = WCNT_W'(MAX_WORKERS);
        end
        else
        begin
            nw_next = WCNT_W'(cfg_reg);
        end
    end

    assign sts.final_job = last_reg;
    assign sts.rank_done = (j_reg == jobs_reg) && !pend_reg;
    assign sts.last_rank = (i_reg == jobs_reg - CNT_W'(1));
    assign sts.scan_done = (wk_reg >= nw_reg);
    assign sts.out_taken = out_valid_reg && !out_stall;
    assign sts.last_asg  = (k_reg == jobs_reg - CNT_W'(1));

    // memories and payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.store && (jobs_reg < CNT_W'(MAX_JOBS)))
        begin
            wmem[jobs_reg[IDX_W-1:0]] <= WT_W'(cols_reg) * WT_W'(rows_reg);
        end
        w_rdata_reg <= wmem[w_raddr];

        if (cmd.rank_write)
        begin
            smem[rank_reg[IDX_W-1:0]] <= i_reg[IDX_W-1:0];
        end
        s_rdata_reg <= smem[k_reg[IDX_W-1:0]];

        if (cmd.capture)
        begin
            cols_reg <= in_data.cols[SIZE_BITS-1:0];
            rows_reg <= in_data.rows[SIZE_BITS-1:0];
            last_reg <= in_data.final_job;
        end

        if (cmd.rank_init)
        begin
            wi_reg <= w_rdata_reg;
        end
        if (cmd.rank_scan)
        begin
            jd_reg <= j_reg;
        end

        if (cmd.asg_fetch)
        begin
            job_reg <= s_rdata_reg;
        end
        if (cmd.asg_init)
        begin
            wt_reg        <= w_rdata_reg;
            best_reg      <= '0;
            best_load_reg <= loads_reg[0];
        end
        if (cmd.asg_scan && (scan_load < best_load_reg))
        begin
            best_reg      <= wk_reg[WID_W-1:0];
            best_load_reg <= scan_load;
        end

        if (cmd.run_start)
        begin
            for (int w = 0; w < MAX_WORKERS; w++)
            begin
                loads_reg[w] <= '0;
            end
        end
        else if (cmd.asg_commit)
        begin
            loads_reg[best_reg] <= best_load_reg + LOAD_W'(wt_reg);
        end

        if (cmd.asg_commit)
        begin
            out_data_reg.job_index  <= JOB_IDX_W'(job_reg);
            out_data_reg.worker_id  <= WORKER_ID_W'(best_reg);
            out_data_reg.end_of_run <= sts.last_asg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_W'(1);
            jobs_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            rank_reg      <= '0;
            pend_reg      <= 1'b0;
            k_reg         <= '0;
            nw_reg        <= WCNT_W'(1);
            wk_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end

            if (cmd.store && (jobs_reg < CNT_W'(MAX_JOBS)))
            begin
                jobs_reg <= jobs_reg + CNT_W'(1);
            end

            if (cmd.run_start)
            begin
                i_reg  <= '0;
                k_reg  <= '0;
                nw_reg <= nw_next;
            end

            if (cmd.rank_init)
            begin
                j_reg    <= '0;
                rank_reg <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.rank_scan)
            begin
                if (j_reg < jobs_reg)
                begin
                    j_reg    <= j_reg + CNT_W'(1);
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
                if (pend_reg && beats_ahead)
                begin
                    rank_reg <= rank_reg + CNT_W'(1);
                end
            end

            if (cmd.rank_write)
            begin
                i_reg <= i_reg + CNT_W'(1);
            end

            if (cmd.asg_init)
            begin
                wk_reg <= WCNT_W'(1);
            end
            else if (cmd.asg_scan)
            begin
                wk_reg <= wk_reg + WCNT_W'(1);
            end

            if (cmd.asg_commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.asg_next)
            begin
                out_valid_reg <= 1'b0;
                k_reg         <= k_reg + CNT_W'(1);
                if (sts.last_asg)
                begin
                    jobs_reg <= '0;
                end
            end
        end
    end

    `GLWA_ASSERT_NOW(a_rank_in_range, cmd.rank_write, rank_reg < jobs_reg, "rank past job count")
    `GLWA_ASSERT_NOW(a_best_in_range, cmd.asg_commit, WCNT_W'(best_reg) < nw_reg, "bad worker")
    `GLWA_ASSERT_NOW(a_jobs_cap, 1'b1, jobs_reg <= CNT_W'(MAX_JOBS), "job count overflow")
    `GLWA_ASSERT_NEXT(a_run_clears, cmd.asg_next && sts.last_asg, jobs_reg == '0, "set not cleared")

endmodule

`default_nettype wire

// ===== rtl/greedy_lpt_work_assigner.sv =====
// Top level of the greedy LPT work assigner.
//
// Jobs arrive one beat at a time as (cols, rows); the weight cols*rows is kept
// in a job memory in arrival order, up to MAX_JOBS jobs (extra jobs are dropped,
// a final mark on a dropped job still starts the run). Each input beat is
// captured, then multiplied and stored. The beat with final_job set starts a
// run: worker loads are cleared, then each job gets its rank in a stable
// descending-weight order by a pass over the job memory through its single
// read port. Then, in rank order, each job is given to the least loaded
// worker (lower index wins ties) by a one-worker-per-cycle load scan; the
// next job waits until its result beat is taken. worker_count 0 acts as 1,
// values above MAX_WORKERS as MAX_WORKERS; it is latched at the start of a
// run. Result beats leave through a registered output, the last of a run with
// end_of_run set; input stall stays high from the final beat until the last
// result beat is taken. The configuration port is always ready.
`default_nettype none

module greedy_lpt_work_assigner #(
    parameter int MAX_JOBS    = 64,
    parameter int MAX_WORKERS = 16,
    parameter int SIZE_BITS   = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // job beats
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire glwa_pkg::in_item_t          in_data,
    // assignment result beats
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output glwa_pkg::out_item_t              out_data,
    // worker_count register
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [glwa_pkg::CFG_W-1:0]  cfg_data
);
    import glwa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencing: load, rank, assign, emit
    glwa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // memories, counters, load scan and result register
    glwa_datapath #(
        .MAX_JOBS    (MAX_JOBS),
        .MAX_WORKERS (MAX_WORKERS),
        .SIZE_BITS   (SIZE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== dv/glwa_assignment_checker.sv =====
// Checker for the greedy LPT work assigner: predicts the assignment beats and compares them.
module glwa_assignment_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  glwa_pkg::in_item_t        in_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  glwa_pkg::out_item_t       out_data,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [glwa_pkg::CFG_W-1:0] cfg_data,
    output int                        fails,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import glwa_pkg::*;

    localparam int JOB_SLOTS    = 64;
    localparam int WORKER_SLOTS = 16;

    logic [31:0]      job_weight [JOB_SLOTS];
    int unsigned      jobs_held;
    logic [CFG_W-1:0] worker_setting;
    out_item_t        assignments_due [$];
    out_item_t        due_beat;

    initial
    begin
        fails   = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fails++;
    endtask

    // Stable descending-weight order, then greedy least-loaded worker per job.
    task automatic plan_assignments();
        logic [JOB_IDX_W-1:0] rank_order [JOB_SLOTS];
        logic [LOAD_W-1:0]    worker_load [WORKER_SLOTS];
        int unsigned          active;
        int unsigned          pos;
        int unsigned          best;
        out_item_t            beat;
        if (worker_setting == 0)
            active = 1;
        else if (worker_setting > WORKER_SLOTS)
            active = WORKER_SLOTS;
        else
            active = worker_setting;
        for (int w = 0; w < WORKER_SLOTS; w++)
            worker_load[w] = '0;
        for (int unsigned i = 0; i < jobs_held; i++)
        begin
            pos = i;
            while (pos > 0 && job_weight[rank_order[pos-1]] < job_weight[i])
            begin
                rank_order[pos] = rank_order[pos-1];
                pos--;
            end
            rank_order[pos] = JOB_IDX_W'(i);
        end
        for (int unsigned k = 0; k < jobs_held; k++)
        begin
            best = 0;
            for (int unsigned w = 1; w < active; w++)
                if (worker_load[w] < worker_load[best])
                    best = w;
            worker_load[best] = worker_load[best] + LOAD_W'(job_weight[rank_order[k]]);
            beat.job_index  = rank_order[k];
            beat.worker_id  = WORKER_ID_W'(best);
            beat.end_of_run = (k + 1 == jobs_held);
            assignments_due = {assignments_due, beat};
        end
        jobs_held = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assignments_due.delete();
            jobs_held      = 0;
            worker_setting = 5'd1;
            pending       <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                worker_setting = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (assignments_due.size() == 0)
                    report_mismatch($sformatf("unexpected beat job %0d worker %0d last %0b",
                        out_data.job_index, out_data.worker_id, out_data.end_of_run));
                else
                begin
                    due_beat = assignments_due.pop_front();
                    if (out_data.job_index !== due_beat.job_index)
                        report_mismatch($sformatf("job_index got %0d want %0d",
                            out_data.job_index, due_beat.job_index));
                    if (out_data.worker_id !== due_beat.worker_id)
                        report_mismatch($sformatf("worker_id got %0d want %0d (job %0d)",
                            out_data.worker_id, due_beat.worker_id, due_beat.job_index));
                    if (out_data.end_of_run !== due_beat.end_of_run)
                        report_mismatch($sformatf("end_of_run got %0b want %0b (job %0d)",
                            out_data.end_of_run, due_beat.end_of_run, due_beat.job_index));
                end
            end
            if (in_valid && !in_stall)
            begin
                // jobs past capacity are dropped, their final mark still counts
                if (jobs_held < JOB_SLOTS)
                begin
                    job_weight[jobs_held] = {16'd0, in_data.cols} * {16'd0, in_data.rows};
                    jobs_held++;
                end
                if (in_data.final_job)
                    plan_assignments();
            end
            pending <= assignments_due.size();
        end
    end

endmodule

// ===== dv/tb_greedy_lpt_work_assigner.sv =====
// Testbench top for the greedy LPT work assigner: stimulus, flow control and verdict.
module tb_greedy_lpt_work_assigner;
    timeunit 1ns;
    timeprecision 1ps;

    import glwa_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_JOBS   = 25;     // minimum accepted beats per random phase
    localparam int LONG_HOLD    = 500;    // receiver hold-off, in cycles
    localparam int SETTLE       = 8;      // idle cycles after the last result

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_item_t         in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    int fails;
    int pending;
    int cycle_count   = 0;
    int send_idle_pct = 0;    // chance per cycle that the sender sits idle
    int stall_pct     = 0;    // chance per cycle that the receiver stalls
    int hold_request  = 0;    // set by the stimulus, picked up by the stall process
    int hold_left     = 0;
    int jobs_sent     = 0;

    // worker_count settings visited by the random phases; 0 and 31 hit the
    // clamp paths (act as 1 and 16), 17 sits just past the top
    logic [CFG_W-1:0] worker_plan [8] = '{5'd16, 5'd31, 5'd0, 5'd3, 5'd1, 5'd17, 5'd7, 5'd12};

    greedy_lpt_work_assigner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    glwa_assignment_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fails     (fails),
        .pending   (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver side. A long hold-off, when requested, overrides the random
    // stall so results back up and the block stops taking job beats.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL greedy_lpt_work_assigner");
            $finish;
        end
    end

    // Offer one job beat and return at the edge where it is taken. Valid stays
    // high on return; the next call either keeps it up or idles first.
    task automatic offer_job(input logic [SIZE_W-1:0] c, input logic [SIZE_W-1:0] r,
                             input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{cols: c, rows: r, final_job: fin};
        do
            @(posedge clk);
        while (in_stall);
        jobs_sent++;
    endtask

    // Stop sending and wait until every predicted result beat has come back,
    // then wait out the settle time so the block is surely idle.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_workers(input logic [CFG_W-1:0] n);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Sizes lean toward tiny values so equal weights (tie cases) show up often.
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return SIZE_W'($urandom_range(1, 4));
            default: return SIZE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly short sets: ranking makes a pass over all stored jobs for each job.
    function automatic int unsigned pick_set_len();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return 1;
        else if (roll < 15)
            return $urandom_range(2, 10);
        else if (roll < 19)
            return $urandom_range(11, 30);
        else
            return $urandom_range(31, 64);
    endfunction

    task automatic offer_set(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            offer_job(pick_size(), pick_size(), i + 1 == n);
    endtask

    initial
    begin
        int phase_base;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed beats ---
        // single-job set at the reset worker count
        offer_job(16'd1, 16'd1, 1'b1);
        drain_results();

        // size extremes, zero sizes, equal weights; 31 saturates to 16 workers
        set_workers(5'd31);
        offer_job(16'hFFFF, 16'hFFFF, 1'b0);
        offer_job(16'd0,    16'd5,    1'b0);
        offer_job(16'd5,    16'd0,    1'b0);
        offer_job(16'd0,    16'd0,    1'b0);
        offer_job(16'd1,    16'hFFFF, 1'b0);
        offer_job(16'hFFFF, 16'd1,    1'b0);
        offer_job(16'd3,    16'd4,    1'b0);
        offer_job(16'd4,    16'd3,    1'b0);
        offer_job(16'd2,    16'd6,    1'b1);
        drain_results();

        // worker count zero acts as one; alternating bit patterns, equal weight
        set_workers(5'd0);
        offer_job(16'hAAAA, 16'h5555, 1'b0);
        offer_job(16'h5555, 16'hAAAA, 1'b1);
        drain_results();

        // all-equal weights with the full worker set go to workers in index order
        set_workers(5'd16);
        offer_job(16'd2, 16'd2, 1'b0);
        offer_job(16'd1, 16'd4, 1'b0);
        offer_job(16'd4, 16'd1, 1'b0);
        offer_job(16'd2, 16'd2, 1'b0);
        offer_job(16'd1, 16'd4, 1'b0);
        offer_job(16'd4, 16'd1, 1'b1);
        drain_results();

        // --- random phases ---
        // idle pattern cycles through: none, sender, receiver, both
        for (int p = 0; p < 8; p++)
        begin
            set_workers(worker_plan[p]);
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 52; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 52; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase

            // receiver holds off while the sender keeps offering sets
            if (p == 4)
                hold_request = LONG_HOLD;

            // capacity overflow: extra jobs dropped, final mark on a dropped job
            if (p == 6)
                offer_set($urandom_range(65, 72));

            phase_base = jobs_sent;
            while (jobs_sent - phase_base < PHASE_JOBS)
                offer_set(pick_set_len());

            // sender pauses until every result of the phase is back
            drain_results();
        end

        if (fails == 0)
            $display("PASS greedy_lpt_work_assigner");
        else
            $display("FAIL greedy_lpt_work_assigner");
        $finish;
    end

endmodule
